[hdl/assert_macros.svh]
// Assertion macros for the checker; clk and arst_n must be in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assert that a property holds at every rising edge out of reset
`define WBMA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// assert that an expression is never true out of reset
`define WBMA_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

[hdl/wbma_pkg.sv]
package wbma_pkg;

	localparam int          MEM_BYTES_DEFAULT = 65536;
	localparam logic [63:0] BASE_RESET        = 64'h0000_0000_8000_0000;

	localparam logic ACT_READ  = 1'b0;
	localparam logic ACT_WRITE = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CALC,
		ST_ACCESS,
		ST_COLLECT
	} state_t;

	typedef struct packed {
		logic wr;
		logic rd;
	} ram_ctl_t;

	// index of the last byte of an access of the given size
	function automatic logic [2:0] last_byte(input logic [1:0] size_code);
		logic [3:0] n;
		n = 4'd1 << size_code;
		return 3'(n - 4'd1);
	endfunction

endpackage

[hdl/wbma_ram.sv]
module wbma_ram #(
	parameter int Depth = wbma_pkg::MEM_BYTES_DEFAULT,
	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  logic                clk,
	input  wbma_pkg::ram_ctl_t  ctl,
	input  logic [AW-1:0]       addr,
	input  logic [7:0]          wdata,
	output logic [7:0]          rdata
);
	import wbma_pkg::*;

	logic [7:0] mem_q [Depth];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem_q[addr] <= wdata;
		end
		if (ctl.rd) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hdl/wbma_seq.sv]
module wbma_seq #(
	parameter int MemBytes = wbma_pkg::MEM_BYTES_DEFAULT,
	localparam int AW = (MemBytes > 1) ? $clog2(MemBytes) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                action,
	input  logic [1:0]          size_code,
	input  logic [63:0]         address,
	input  logic [63:0]         write_data,
	input  logic [63:0]         base,
	output wbma_pkg::ram_ctl_t  ram_ctl,
	output logic [AW-1:0]       ram_addr,
	output logic [7:0]          ram_wdata,
	input  logic [7:0]          ram_rdata,
	output logic                read_valid,
	output logic [63:0]         read_data
);
	import wbma_pkg::*;

	state_t         state_q, state_d;
	logic [AW-1:0]  clr_q;
	logic [2:0]     cnt_q;
	logic           valid_q;
	logic           act_q;
	logic [2:0]     last_q;
	logic [63:0]    cur_q;
	logic [63:0]    wdata_q;
	logic [63:0]    rdata_q;
	logic [AW-1:0]  idx_q;
	logic [63:0]    off;
	logic           in_win;
	logic           advance;
	logic           finish;

	// shared offset unit: one subtract and compare per byte
	assign off    = cur_q - base;
	assign in_win = off < 64'(MemBytes);
	assign finish = advance && (cnt_q == last_q);

	always_comb begin
		state_d   = state_q;
		advance   = 1'b0;
		ram_ctl   = '0;
		ram_addr  = idx_q;
		ram_wdata = wdata_q[7:0];
		case (state_q)
			ST_CLEAR: begin
				ram_ctl.wr = 1'b1;
				ram_addr   = clr_q;
				ram_wdata  = 8'h00;
				if (clr_q == AW'(MemBytes - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					state_d = ST_CALC;
				end
			end
			ST_CALC: begin
				if (in_win) begin
					state_d = ST_ACCESS;
				end else begin
					advance = 1'b1;
				end
			end
			ST_ACCESS: begin
				if (act_q == ACT_WRITE) begin
					ram_ctl.wr = 1'b1;
					advance    = 1'b1;
				end else begin
					ram_ctl.rd = 1'b1;
					state_d    = ST_COLLECT;
				end
			end
			ST_COLLECT: begin
				advance = 1'b1;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (advance) begin
			state_d = (cnt_q == last_q) ? ST_IDLE : ST_CALC;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			cnt_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			valid_q <= finish && (act_q == ACT_READ);
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (state_q == ST_IDLE && start) begin
				cnt_q <= '0;
			end else if (advance) begin
				cnt_q <= cnt_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			act_q   <= action;
			last_q  <= last_byte(size_code);
			cur_q   <= address;
			wdata_q <= write_data;
			rdata_q <= '0;
		end else begin
			if (state_q == ST_CALC) begin
				idx_q <= off[AW-1:0];
			end
			if (state_q == ST_COLLECT) begin
				rdata_q <= rdata_q | ({56'b0, ram_rdata} << {cnt_q, 3'b000});
			end
			if (advance) begin
				cur_q   <= cur_q + 64'd1;
				wdata_q <= {8'h00, wdata_q[63:8]};
			end
		end
	end

	assign busy       = state_q != ST_IDLE;
	assign read_valid = valid_q;
	assign read_data  = rdata_q;

endmodule

[hdl/windowed_byte_memory_access_core.sv]
// Byte-addressed memory window of MEM_BYTES bytes at base_address. After reset the
// block clears every byte of its store with busy high. A request is taken when start
// is high and busy low; its bytes are handled one at a time by a shared offset
// subtract-and-compare and a single-port byte RAM: a byte outside the window passes
// only the check, a byte written the check and a RAM write, a byte read the check, a
// RAM read and a collect step; busy stays high until the last byte is done. A read
// shows read_data for exactly one cycle with read_valid, in the cycle busy falls;
// there is no way to stall it, so sample it then. base_address is written through
// cfg_valid/cfg_ready; write it only while busy is low: the block does not enforce it.
module windowed_byte_memory_access_core #(
	parameter int MEM_BYTES = wbma_pkg::MEM_BYTES_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        action,
	input  logic [1:0]  size_code,
	input  logic [63:0] address,
	input  logic [63:0] write_data,
	output logic        read_valid,
	output logic [63:0] read_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [63:0] base_address
);
	import wbma_pkg::*;

	localparam int AW = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;

	logic [63:0]   base_q;
	ram_ctl_t      ram_ctl;
	logic [AW-1:0] ram_addr;
	logic [7:0]    ram_wdata;
	logic [7:0]    ram_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			base_q <= base_address;
		end
	end

	wbma_seq #(
		.MemBytes (MEM_BYTES)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.action     (action),
		.size_code  (size_code),
		.address    (address),
		.write_data (write_data),
		.base       (base_q),
		.ram_ctl    (ram_ctl),
		.ram_addr   (ram_addr),
		.ram_wdata  (ram_wdata),
		.ram_rdata  (ram_rdata),
		.read_valid (read_valid),
		.read_data  (read_data)
	);

	wbma_ram #(
		.Depth (MEM_BYTES)
	) u_ram (
		.clk   (clk),
		.ctl   (ram_ctl),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

endmodule

[hdl/wbma_chk.sv]
`include "assert_macros.svh"

module wbma_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        action,
	input logic        read_valid
);
	import wbma_pkg::*;

	`WBMA_ASSERT(a_result_after_work, read_valid |-> $past(busy), "result without preceding work")
	`WBMA_ASSERT(a_busy_after_take, (start && !busy) |=> busy, "request taken but not busy")
	`WBMA_ASSERT(a_no_result_on_take, (start && !busy) |=> !read_valid, "result right after take")
	`WBMA_ASSERT(a_single_strobe, read_valid |=> !read_valid, "result strobe longer than a cycle")
	`WBMA_NEVER(a_write_no_result, $past(start && !busy && action == ACT_WRITE) && read_valid,
		"result for a write")

endmodule

bind windowed_byte_memory_access_core wbma_chk u_wbma_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.action     (action),
	.read_valid (read_valid)
);
